@@ src/cie_pkg.sv @@
`timescale 1ns / 1ps

package cie_pkg;

    localparam int unsigned INSTR_W = 16;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned IMM_W   = 18;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic CFG_RV64_MODE = 1'b0;

    typedef enum logic [4:0] {
        OP_LW     = 5'd0,
        OP_SW     = 5'd1,
        OP_BEQ    = 5'd2,
        OP_BNE    = 5'd3,
        OP_ADDI   = 5'd4,
        OP_ADD    = 5'd5,
        OP_JAL    = 5'd6,
        OP_JALR   = 5'd7,
        OP_SUB    = 5'd8,
        OP_XOR    = 5'd9,
        OP_OR     = 5'd10,
        OP_AND    = 5'd11,
        OP_ANDI   = 5'd12,
        OP_SLLI   = 5'd13,
        OP_SRLI   = 5'd14,
        OP_SRAI   = 5'd15,
        OP_ADDIW  = 5'd16,
        OP_ADDW   = 5'd17,
        OP_SUBW   = 5'd18,
        OP_LD     = 5'd19,
        OP_SD     = 5'd20,
        OP_EBREAK = 5'd21
    } op_kind_t;

    // Quadrant codes (instruction bits 1:0).
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Fixed register numbers.
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

endpackage

@@ src/cie_in_if.sv @@
`timescale 1ns / 1ps

interface cie_in_if;
    logic                              valid;
    logic                              ready;
    logic [cie_pkg::INSTR_W-1:0]       instr_half;

    modport source (output valid, output instr_half, input ready);
    modport sink   (input valid, input instr_half, output ready);
endinterface

@@ src/cie_out_if.sv @@
`timescale 1ns / 1ps

interface cie_out_if;
    logic                              valid;
    logic                              ready;
    logic                              legal;
    cie_pkg::op_kind_t                 op_kind;
    logic [cie_pkg::REG_W-1:0]         dest_reg;
    logic [cie_pkg::REG_W-1:0]         src1_reg;
    logic [cie_pkg::REG_W-1:0]         src2_reg;
    logic signed [cie_pkg::IMM_W-1:0]  immediate;

    modport source (output valid, output legal, output op_kind, output dest_reg,
                    output src1_reg, output src2_reg, output immediate, input ready);
    modport sink   (input valid, input legal, input op_kind, input dest_reg,
                    input src1_reg, input src2_reg, input immediate, output ready);
endinterface

@@ src/compressed_instruction_expander.sv @@
`timescale 1ns / 1ps

// Expands one 16-bit RVC instruction per transfer into an operation code, three
// register numbers, a sign-extended 18-bit immediate and a legal flag. The block
// is a two-register pipeline: the instruction is captured in an input register,
// decoded by one level of combinational logic and stored in the result register.
// A new instruction is accepted every cycle while the output side keeps taking
// results. The input stalls only while both registers hold an instruction and the
// output is not ready. The rv64_mode register (APB offset 0, reset 0) selects RV64C
// decoding; write it only while no instruction is in flight. Illegal encodings
// give legal = 0 with every other field zero.
module compressed_instruction_expander (
    input  logic                          clk,
    input  logic                          rst_n,
    cie_in_if.sink                        in_ch,
    cie_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cie_pkg::ADDR_W-1:0]    paddr,
    input  logic [cie_pkg::DATA_W-1:0]    pwdata,
    output logic [cie_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                              rv64_mode_reg;
    logic                              cfg_write;

    logic                              s1_valid_reg;
    logic [cie_pkg::INSTR_W-1:0]       s1_instr_reg;
    logic                              out_valid_reg;
    logic                              legal_reg;
    cie_pkg::op_kind_t                 op_kind_reg;
    logic [cie_pkg::REG_W-1:0]         dest_reg_reg;
    logic [cie_pkg::REG_W-1:0]         src1_reg_reg;
    logic [cie_pkg::REG_W-1:0]         src2_reg_reg;
    logic signed [cie_pkg::IMM_W-1:0]  immediate_reg;

    logic                              out_advance;
    logic                              in_take;

    logic                              legal_next;
    cie_pkg::op_kind_t                 op_kind_next;
    logic [cie_pkg::REG_W-1:0]         dest_reg_next;
    logic [cie_pkg::REG_W-1:0]         src1_reg_next;
    logic [cie_pkg::REG_W-1:0]         src2_reg_next;
    logic signed [cie_pkg::IMM_W-1:0]  immediate_next;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == cie_pkg::CFG_RV64_MODE);
    assign prdata    = (paddr[2] == cie_pkg::CFG_RV64_MODE)
                       ? {{(cie_pkg::DATA_W-1){1'b0}}, rv64_mode_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv64_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            rv64_mode_reg <= pwdata[0];
        end
    end

    // Pipeline flow control
    assign out_advance = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_instr_reg <= in_ch.instr_half;
        end
        if (out_advance && s1_valid_reg)
        begin
            legal_reg     <= legal_next;
            op_kind_reg   <= op_kind_next;
            dest_reg_reg  <= dest_reg_next;
            src1_reg_reg  <= src1_reg_next;
            src2_reg_reg  <= src2_reg_next;
            immediate_reg <= immediate_next;
        end
    end

    // Decoder
    logic [2:0]                        f3;
    logic [4:0]                        rdf;
    logic [4:0]                        rs2f;
    logic [4:0]                        rp7;
    logic [4:0]                        rp2;
    logic                              b12;
    logic signed [cie_pkg::IMM_W-1:0]  imm6;
    logic [cie_pkg::IMM_W-1:0]         shamt;
    logic [cie_pkg::IMM_W-1:0]         imm_addi4spn;
    logic [cie_pkg::IMM_W-1:0]         imm_lw;
    logic [cie_pkg::IMM_W-1:0]         imm_ld;
    logic signed [cie_pkg::IMM_W-1:0]  imm_jal;
    logic signed [cie_pkg::IMM_W-1:0]  imm_addi16sp;
    logic signed [cie_pkg::IMM_W-1:0]  imm_lui;
    logic signed [cie_pkg::IMM_W-1:0]  imm_branch;
    logic [cie_pkg::IMM_W-1:0]         imm_lwsp;
    logic [cie_pkg::IMM_W-1:0]         imm_swsp;
    logic                              r64;

    always_comb
    begin
        f3   = s1_instr_reg[15:13];
        rdf  = s1_instr_reg[11:7];
        rs2f = s1_instr_reg[6:2];
        rp7  = {2'b01, s1_instr_reg[9:7]};
        rp2  = {2'b01, s1_instr_reg[4:2]};
        b12  = s1_instr_reg[12];
        r64  = rv64_mode_reg;

        imm6  = {{12{b12}}, b12, rs2f};
        shamt = {12'd0, b12, rs2f};
        imm_addi4spn = {8'd0, s1_instr_reg[10:7], s1_instr_reg[12:11],
                        s1_instr_reg[5], s1_instr_reg[6], 2'b00};
        imm_lw = {11'd0, s1_instr_reg[5], s1_instr_reg[12:10], s1_instr_reg[6], 2'b00};
        imm_ld = {10'd0, s1_instr_reg[6:5], s1_instr_reg[12:10], 3'b000};
        imm_jal = {{6{b12}}, b12, s1_instr_reg[8], s1_instr_reg[10:9], s1_instr_reg[6],
                   s1_instr_reg[7], s1_instr_reg[2], s1_instr_reg[11],
                   s1_instr_reg[5:3], 1'b0};
        imm_addi16sp = {{8{b12}}, b12, s1_instr_reg[4:3], s1_instr_reg[5],
                        s1_instr_reg[2], s1_instr_reg[6], 4'b0000};
        imm_lui = {b12, rs2f, 12'd0};
        imm_branch = {{9{b12}}, b12, s1_instr_reg[6:5], s1_instr_reg[2],
                      s1_instr_reg[11:10], s1_instr_reg[4:3], 1'b0};
        imm_lwsp = {10'd0, s1_instr_reg[3:2], b12, s1_instr_reg[6:4], 2'b00};
        imm_swsp = {10'd0, s1_instr_reg[8:7], s1_instr_reg[12:9], 2'b00};

        legal_next     = 1'b0;
        op_kind_next   = cie_pkg::OP_LW;
        dest_reg_next  = cie_pkg::REG_ZERO;
        src1_reg_next  = cie_pkg::REG_ZERO;
        src2_reg_next  = cie_pkg::REG_ZERO;
        immediate_next = '0;

        unique case (s1_instr_reg[1:0])
            cie_pkg::QUAD_0:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        if (imm_addi4spn != '0)
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_ADDI;
                            dest_reg_next  = rp2;
                            src1_reg_next  = cie_pkg::REG_SP;
                            immediate_next = imm_addi4spn;
                        end
                    end
                    3'd2:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = cie_pkg::OP_LW;
                        dest_reg_next  = rp2;
                        src1_reg_next  = rp7;
                        immediate_next = imm_lw;
                    end
                    3'd6:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = cie_pkg::OP_SW;
                        src1_reg_next  = rp7;
                        src2_reg_next  = rp2;
                        immediate_next = imm_lw;
                    end
                    3'd3:
                    begin
                        if (r64)
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_LD;
                            dest_reg_next  = rp2;
                            src1_reg_next  = rp7;
                            immediate_next = imm_ld;
                        end
                    end
                    3'd7:
                    begin
                        if (r64)
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_SD;
                            src1_reg_next  = rp7;
                            src2_reg_next  = rp2;
                            immediate_next = imm_ld;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            cie_pkg::QUAD_1:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = cie_pkg::OP_ADDI;
                        dest_reg_next  = rdf;
                        src1_reg_next  = rdf;
                        immediate_next = imm6;
                    end
                    3'd1, 3'd5:
                    begin
                        // In RV64 the f3=1 slot is ADDIW instead of JAL.
                        if (f3 == 3'd1 && r64)
                        begin
                            if (rdf != cie_pkg::REG_ZERO)
                            begin
                                legal_next     = 1'b1;
                                op_kind_next   = cie_pkg::OP_ADDIW;
                                dest_reg_next  = rdf;
                                src1_reg_next  = rdf;
                                immediate_next = imm6;
                            end
                        end
                        else
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_JAL;
                            dest_reg_next  = (f3 == 3'd1) ? cie_pkg::REG_RA : cie_pkg::REG_ZERO;
                            immediate_next = imm_jal;
                        end
                    end
                    3'd2:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = cie_pkg::OP_ADDI;
                        dest_reg_next  = rdf;
                        immediate_next = imm6;
                    end
                    3'd3:
                    begin
                        if (rdf == cie_pkg::REG_SP)
                        begin
                            if (imm_addi16sp != '0)
                            begin
                                legal_next     = 1'b1;
                                op_kind_next   = cie_pkg::OP_ADDI;
                                dest_reg_next  = cie_pkg::REG_SP;
                                src1_reg_next  = cie_pkg::REG_SP;
                                immediate_next = imm_addi16sp;
                            end
                        end
                        else if ({b12, rs2f} != 6'd0)
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_ADDI;
                            dest_reg_next  = rdf;
                            immediate_next = imm_lui;
                        end
                    end
                    3'd4:
                    begin
                        unique case (s1_instr_reg[11:10])
                            2'd0, 2'd1:
                            begin
                                if (!(b12 && !r64))
                                begin
                                    legal_next     = 1'b1;
                                    op_kind_next   = (s1_instr_reg[11:10] == 2'd0)
                                                     ? cie_pkg::OP_SRLI : cie_pkg::OP_SRAI;
                                    dest_reg_next  = rp7;
                                    src1_reg_next  = rp7;
                                    immediate_next = shamt;
                                end
                            end
                            2'd2:
                            begin
                                legal_next     = 1'b1;
                                op_kind_next   = cie_pkg::OP_ANDI;
                                dest_reg_next  = rp7;
                                src1_reg_next  = rp7;
                                immediate_next = imm6;
                            end
                            default:
                            begin
                                if (!b12)
                                begin
                                    legal_next    = 1'b1;
                                    dest_reg_next = rp7;
                                    src1_reg_next = rp7;
                                    src2_reg_next = rp2;
                                    unique case (s1_instr_reg[6:5])
                                        2'd0:    op_kind_next = cie_pkg::OP_SUB;
                                        2'd1:    op_kind_next = cie_pkg::OP_XOR;
                                        2'd2:    op_kind_next = cie_pkg::OP_OR;
                                        default: op_kind_next = cie_pkg::OP_AND;
                                    endcase
                                end
                                else if (r64 && !s1_instr_reg[6])
                                begin
                                    legal_next    = 1'b1;
                                    op_kind_next  = s1_instr_reg[5]
                                                    ? cie_pkg::OP_ADDW : cie_pkg::OP_SUBW;
                                    dest_reg_next = rp7;
                                    src1_reg_next = rp7;
                                    src2_reg_next = rp2;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = (f3 == 3'd6) ? cie_pkg::OP_BEQ : cie_pkg::OP_BNE;
                        src1_reg_next  = rp7;
                        immediate_next = imm_branch;
                    end
                endcase
            end
            cie_pkg::QUAD_2:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        if (!(b12 && !r64))
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_SLLI;
                            dest_reg_next  = rdf;
                            src1_reg_next  = rdf;
                            immediate_next = shamt;
                        end
                    end
                    3'd2:
                    begin
                        if (rdf != cie_pkg::REG_ZERO)
                        begin
                            legal_next     = 1'b1;
                            op_kind_next   = cie_pkg::OP_LW;
                            dest_reg_next  = rdf;
                            src1_reg_next  = cie_pkg::REG_SP;
                            immediate_next = imm_lwsp;
                        end
                    end
                    3'd4:
                    begin
                        if (!b12)
                        begin
                            if (rs2f == cie_pkg::REG_ZERO)
                            begin
                                if (rdf != cie_pkg::REG_ZERO)
                                begin
                                    legal_next    = 1'b1;
                                    op_kind_next  = cie_pkg::OP_JALR;
                                    src1_reg_next = rdf;
                                end
                            end
                            else
                            begin
                                legal_next    = 1'b1;
                                op_kind_next  = cie_pkg::OP_ADDI;
                                dest_reg_next = rdf;
                                src1_reg_next = rs2f;
                            end
                        end
                        else if (rs2f == cie_pkg::REG_ZERO)
                        begin
                            legal_next = 1'b1;
                            if (rdf == cie_pkg::REG_ZERO)
                            begin
                                op_kind_next = cie_pkg::OP_EBREAK;
                            end
                            else
                            begin
                                op_kind_next  = cie_pkg::OP_JALR;
                                dest_reg_next = cie_pkg::REG_RA;
                                src1_reg_next = rdf;
                            end
                        end
                        else
                        begin
                            legal_next    = 1'b1;
                            op_kind_next  = cie_pkg::OP_ADD;
                            dest_reg_next = rdf;
                            src1_reg_next = rdf;
                            src2_reg_next = rs2f;
                        end
                    end
                    3'd6:
                    begin
                        legal_next     = 1'b1;
                        op_kind_next   = cie_pkg::OP_SW;
                        src1_reg_next  = cie_pkg::REG_SP;
                        src2_reg_next  = rs2f;
                        immediate_next = imm_swsp;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                // 32-bit encodings are not handled here.
            end
        endcase
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.legal     = legal_reg;
    assign out_ch.op_kind   = op_kind_reg;
    assign out_ch.dest_reg  = dest_reg_reg;
    assign out_ch.src1_reg  = src1_reg_reg;
    assign out_ch.src2_reg  = src2_reg_reg;
    assign out_ch.immediate = immediate_reg;

endmodule
